FILE: rtl/assert_macros.svh
// assertion macros shared by the frame checker rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge outside reset
`define ASSERT_CLK(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// checked at every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

FILE: rtl/crcfc_pkg.sv
// package for the crc-16 frame checker: codes, reset constants, crc byte update
// no dependencies
package crcfc_pkg;

    localparam logic [7:0]  HEADER_RESET = 8'h31;
    localparam logic [7:0]  LIMIT_RESET  = 8'h31;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [7:0]  MIN_LENGTH   = 8'd2;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2,
        PH_CRC  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_HUNT   = 2'd0,
        ST_INSIDE = 2'd1,
        ST_GOOD   = 2'd2,
        ST_BAD    = 2'd3
    } status_t;

    typedef enum logic {
        REG_HEADER = 1'b0,
        REG_LIMIT  = 1'b1
    } cfg_reg_t;

    // reflected modbus crc, one byte, lsb first
    function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

FILE: rtl/crc16_frame_checker.sv
// top level of the crc-16 frame checker: input register, frame fsm, result register
// depends on crcfc_pkg and assert_macros.svh
//
// input beat: rx_byte with in_valid, taken at a rising edge with in_valid high and
//   in_stall low; every byte gives exactly one result beat
// result beat: echo_byte, in_frame, frame_status, frame_length with out_valid, taken
//   at a rising edge with out_valid high and out_stall low
//   frame_status: 0 hunting, 1 inside frame, 2 frame good, 3 crc mismatch
//   frame_length: declared length plus the two crc bytes on a good frame, else zero
// config: cfg_index selects header_value (0) or length_limit (1), cfg_data is written
//   when cfg_valid and cfg_ready are high; cfg_ready is always high, write only
//   while no byte is in flight
// path: an accepted byte passes the input register, then the result register, to its result
//   beat; throughput one byte per cycle while out_stall is low, set by the byte-wide crc
//   update and frame state step
// reset: rst_n low returns to hunting, crc to 0xffff, registers to 0x31, and empties
//   the input and result registers
// stall: while out_stall holds a result, a byte in the input register waits and
//   in_stall rises; one more byte is still taken while the input register is empty
`include "assert_macros.svh"

module crc16_frame_checker
(
    input  logic       clk,
    input  logic       rst_n,
    // input beat
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    // result beat
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] echo_byte,
    output logic       in_frame,
    output logic [1:0] frame_status,
    output logic [8:0] frame_length,
    // config writes
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    // configuration registers
    logic [7:0] header_value_reg;
    logic [7:0] length_limit_reg;

    // input register stage
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_byte_reg;

    // frame state
    crcfc_pkg::phase_t phase_reg;
    crcfc_pkg::phase_t phase_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [7:0]  byte_count_reg;
    logic [7:0]  byte_count_next;
    logic [7:0]  declared_length_reg;
    logic [7:0]  declared_length_next;
    logic [7:0]  crc_high_reg;
    logic [7:0]  crc_high_next;

    // result register
    logic              out_valid_reg;
    logic [7:0]        echo_reg;
    logic              in_frame_reg;
    logic              in_frame_next;
    crcfc_pkg::status_t status_reg;
    crcfc_pkg::status_t status_next;
    logic [8:0]        length_reg;
    logic [8:0]        length_next;

    logic        advance;
    logic        in_accept;
    logic        step;
    logic [15:0] crc_cont;
    logic [15:0] crc_fresh;
    logic [7:0]  count_inc;
    logic        len_ok;

    // handshake: result register frees when empty or taken this cycle
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign step      = advance && s1_valid_reg;
    assign cfg_ready = 1'b1;

    assign s1_valid_next = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_value_reg <= crcfc_pkg::HEADER_RESET;
            length_limit_reg <= crcfc_pkg::LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                crcfc_pkg::REG_HEADER: header_value_reg <= cfg_data;
                crcfc_pkg::REG_LIMIT:  length_limit_reg <= cfg_data;
                default:               header_value_reg <= header_value_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            s1_byte_reg <= rx_byte;
    end

    // crc updates shared by the hunt, length and body phases
    assign crc_cont  = crcfc_pkg::crc_step(crc_reg, s1_byte_reg);
    assign crc_fresh = crcfc_pkg::crc_step(crcfc_pkg::CRC_INIT, s1_byte_reg);
    assign count_inc = byte_count_reg + 8'd1;
    assign len_ok    = (s1_byte_reg >= crcfc_pkg::MIN_LENGTH) &&
                       (s1_byte_reg < length_limit_reg);

    // next frame state and result fields for the byte in the input register
    always_comb
    begin
        phase_next           = phase_reg;
        crc_next             = crc_reg;
        byte_count_next      = byte_count_reg;
        declared_length_next = declared_length_reg;
        crc_high_next        = crc_high_reg;
        in_frame_next        = 1'b0;
        status_next          = crcfc_pkg::ST_HUNT;
        length_next          = 9'd0;
        case (phase_reg)
            crcfc_pkg::PH_HUNT:
            begin
                if (s1_byte_reg == header_value_reg)
                begin
                    crc_next      = crc_fresh;
                    phase_next    = crcfc_pkg::PH_LEN;
                    in_frame_next = 1'b1;
                    status_next   = crcfc_pkg::ST_INSIDE;
                end
            end
            crcfc_pkg::PH_LEN:
            begin
                if (len_ok)
                begin
                    declared_length_next = s1_byte_reg;
                    crc_next             = crc_cont;
                    byte_count_next      = crcfc_pkg::MIN_LENGTH;
                    phase_next           = (s1_byte_reg == crcfc_pkg::MIN_LENGTH) ?
                                           crcfc_pkg::PH_CRC : crcfc_pkg::PH_BODY;
                    in_frame_next        = 1'b1;
                    status_next          = crcfc_pkg::ST_INSIDE;
                end
                else if (s1_byte_reg == header_value_reg)
                begin
                    // header seen where a length was due: restart candidate
                    crc_next      = crc_fresh;
                    phase_next    = crcfc_pkg::PH_LEN;
                    in_frame_next = 1'b1;
                    status_next   = crcfc_pkg::ST_INSIDE;
                end
                else
                begin
                    phase_next = crcfc_pkg::PH_HUNT;
                end
            end
            crcfc_pkg::PH_BODY:
            begin
                crc_next        = crc_cont;
                byte_count_next = count_inc;
                if (count_inc >= declared_length_reg)
                    phase_next = crcfc_pkg::PH_CRC;
                in_frame_next   = 1'b1;
                status_next     = crcfc_pkg::ST_INSIDE;
            end
            crcfc_pkg::PH_CRC:
            begin
                in_frame_next = 1'b1;
                if (byte_count_reg == declared_length_reg)
                begin
                    crc_high_next   = s1_byte_reg;
                    byte_count_next = count_inc;
                    status_next     = crcfc_pkg::ST_INSIDE;
                end
                else
                begin
                    if ({crc_high_reg, s1_byte_reg} == crc_reg)
                    begin
                        status_next = crcfc_pkg::ST_GOOD;
                        length_next = {1'b0, declared_length_reg} + 9'd2;
                    end
                    else
                    begin
                        status_next = crcfc_pkg::ST_BAD;
                    end
                    phase_next = crcfc_pkg::PH_HUNT;
                end
            end
            default:
            begin
                phase_next = crcfc_pkg::PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= crcfc_pkg::PH_HUNT;
            crc_reg             <= crcfc_pkg::CRC_INIT;
            byte_count_reg      <= 8'd0;
            declared_length_reg <= 8'd0;
            crc_high_reg        <= 8'd0;
        end
        else if (step)
        begin
            phase_reg           <= phase_next;
            crc_reg             <= crc_next;
            byte_count_reg      <= byte_count_next;
            declared_length_reg <= declared_length_next;
            crc_high_reg        <= crc_high_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            echo_reg     <= s1_byte_reg;
            in_frame_reg <= in_frame_next;
            status_reg   <= status_next;
            length_reg   <= length_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign echo_byte    = echo_reg;
    assign in_frame     = in_frame_reg;
    assign frame_status = status_reg;
    assign frame_length = length_reg;

    // a good frame always reports at least header, length and two crc bytes
    `ASSERT_CLK(a_good_len, clk, rst_n,
        (out_valid_reg && status_reg == crcfc_pkg::ST_GOOD) |-> (length_reg >= 9'd4),
        "good frame with short length")

    // a byte outside any frame is always reported as hunting
    `ASSERT_CLK(a_hunt_out, clk, rst_n,
        (out_valid_reg && !in_frame_reg) |-> (status_reg == crcfc_pkg::ST_HUNT),
        "status set on a byte outside a frame")

    // body count stays below the declared length
    `ASSERT_CLK(a_body_count, clk, rst_n,
        (phase_reg == crcfc_pkg::PH_BODY) |-> (byte_count_reg < declared_length_reg),
        "body count past declared length")

    // in the crc phase only the two crc byte positions are possible
    `ASSERT_CLK(a_crc_count, clk, rst_n,
        (phase_reg == crcfc_pkg::PH_CRC) |->
            (byte_count_reg == declared_length_reg ||
             {1'b0, byte_count_reg} == {1'b0, declared_length_reg} + 9'd1),
        "crc byte position out of range")

    // input only backs up behind a held byte
    `ASSERT_ALWAYS(a_stall_src, clk,
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall),
        "input stall without a held byte")

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for crc16_frame_checker: directed byte table, then random frames
// depends on crcfc_pkg and the crc16_frame_checker rtl; nothing else is read at run time
module testbench;

    // generous ceiling on run length, in clock cycles
    localparam int unsigned CYCLE_LIMIT = 200000;
    // receiver hold-off length used to back the pipeline up into the input side
    localparam int unsigned HOLD_CYCLES = 80;

    // how a directed row builds its byte
    typedef enum logic [1:0] {
        SRC_LIT,      // byte typed into the table
        SRC_CRC_HI,   // high byte of the running frame crc
        SRC_CRC_LO,   // low byte of the running frame crc
        SRC_CRC_BAD   // low byte of the running frame crc, inverted
    } byte_src_t;

    // one result beat as the block should present it
    typedef struct {
        logic [7:0]         echo;
        logic               inf;
        crcfc_pkg::status_t status;
        logic [8:0]         flen;
    } frame_beat_t;

    // one row of the directed table
    typedef struct {
        byte_src_t   src;
        logic [7:0]  value;
        bit          typed;   // expectation typed in rather than predicted
        frame_beat_t want;
    } script_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] echo_byte;
    logic       in_frame;
    logic [1:0] frame_status;
    logic [8:0] frame_length;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = crcfc_pkg::REG_HEADER;
    logic [7:0] cfg_data = 8'h00;

    // results owed by the block, oldest first
    frame_beat_t expected_beats[$];
    script_row_t script[$];

    int unsigned mismatches = 0;
    int unsigned bytes_sent = 0;
    int unsigned cycles = 0;

    // traffic shaping shared between the sender and the receiver
    bit          calm = 1'b0;     // no idling on either side while set
    int unsigned hold_ask = 0;    // bumped by the sender to request a long hold-off
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    // shadow copy of the configuration and of the frame tracker state
    logic [7:0]        hdr_cfg = crcfc_pkg::HEADER_RESET;
    logic [7:0]        lim_cfg = crcfc_pkg::LIMIT_RESET;
    crcfc_pkg::phase_t trk_phase = crcfc_pkg::PH_HUNT;
    logic [15:0]       trk_crc = crcfc_pkg::CRC_INIT;
    logic [7:0]        trk_count = 8'd0;
    logic [7:0]        trk_dlen = 8'd0;
    logic [7:0]        trk_crc_hi = 8'd0;

    crc16_frame_checker uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .echo_byte    (echo_byte),
        .in_frame     (in_frame),
        .frame_status (frame_status),
        .frame_length (frame_length),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // modbus crc-16, reflected, one byte shifted in lsb first
    function automatic logic [15:0] crc16_modbus(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c  = {1'b0, c[15:1]};
            if (fb)
                c = c ^ crcfc_pkg::CRC_POLY;
        end
        return c;
    endfunction

    // frame tracker: advances the shadow state by one byte and returns the beat it causes
    function automatic frame_beat_t predict_frame_beat(input logic [7:0] b);
        frame_beat_t r;
        r.echo   = b;
        r.inf    = 1'b0;
        r.status = crcfc_pkg::ST_HUNT;
        r.flen   = 9'd0;
        case (trk_phase)
            crcfc_pkg::PH_HUNT:
            begin
                if (b == hdr_cfg)
                begin
                    trk_crc   = crc16_modbus(crcfc_pkg::CRC_INIT, b);
                    trk_phase = crcfc_pkg::PH_LEN;
                    r.inf     = 1'b1;
                    r.status  = crcfc_pkg::ST_INSIDE;
                end
            end
            crcfc_pkg::PH_LEN:
            begin
                if (b >= crcfc_pkg::MIN_LENGTH && b < lim_cfg)
                begin
                    trk_dlen  = b;
                    trk_crc   = crc16_modbus(trk_crc, b);
                    trk_count = 8'd2;
                    trk_phase = (b == crcfc_pkg::MIN_LENGTH) ?
                                crcfc_pkg::PH_CRC : crcfc_pkg::PH_BODY;
                    r.inf     = 1'b1;
                    r.status  = crcfc_pkg::ST_INSIDE;
                end
                else if (b == hdr_cfg)
                begin
                    // rejected length that matches the header restarts the candidate
                    trk_crc   = crc16_modbus(crcfc_pkg::CRC_INIT, b);
                    trk_phase = crcfc_pkg::PH_LEN;
                    r.inf     = 1'b1;
                    r.status  = crcfc_pkg::ST_INSIDE;
                end
                else
                    trk_phase = crcfc_pkg::PH_HUNT;
            end
            crcfc_pkg::PH_BODY:
            begin
                trk_crc   = crc16_modbus(trk_crc, b);
                trk_count = trk_count + 8'd1;
                if (trk_count >= trk_dlen)
                    trk_phase = crcfc_pkg::PH_CRC;
                r.inf    = 1'b1;
                r.status = crcfc_pkg::ST_INSIDE;
            end
            default:
            begin
                r.inf = 1'b1;
                if (trk_count == trk_dlen)
                begin
                    trk_crc_hi = b;
                    trk_count  = trk_count + 8'd1;
                    r.status   = crcfc_pkg::ST_INSIDE;
                end
                else
                begin
                    if ({trk_crc_hi, b} == trk_crc)
                    begin
                        r.status = crcfc_pkg::ST_GOOD;
                        r.flen   = {1'b0, trk_dlen} + 9'd2;
                    end
                    else
                        r.status = crcfc_pkg::ST_BAD;
                    trk_phase = crcfc_pkg::PH_HUNT;
                end
            end
        endcase
        return r;
    endfunction

    // offer one byte, with random idle cycles ahead of it, and log what it must produce
    task automatic send_byte(input logic [7:0] b, input bit typed, input frame_beat_t want);
        frame_beat_t pred;
        while (!calm && $urandom_range(99) < 33)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // beat taken at this edge
        pred = predict_frame_beat(b);
        expected_beats.push_back(typed ? want : pred);
        bytes_sent++;
    endtask

    task automatic send_plain(input logic [7:0] b);
        frame_beat_t none;
        none.echo   = 8'h00;
        none.inf    = 1'b0;
        none.status = crcfc_pkg::ST_HUNT;
        none.flen   = 9'd0;
        send_byte(b, 1'b0, none);
    endtask

    // drop valid and wait until every owed result beat has come back
    task automatic drain;
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input crcfc_pkg::cfg_reg_t idx, input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == crcfc_pkg::REG_HEADER)
            hdr_cfg = v;
        else
            lim_cfg = v;
        @(posedge clk);
    endtask

    // new settings only once the pipe is empty, plus a margin of idle clocks
    task automatic reconfigure(input logic [7:0] hdr, input logic [7:0] lim);
        drain;
        repeat (4) @(posedge clk);
        write_reg(crcfc_pkg::REG_HEADER, hdr);
        write_reg(crcfc_pkg::REG_LIMIT, lim);
    endtask

    // whole frame: header, length, body, crc high then low; optionally with a bad crc
    task automatic send_frame(input int len, input bit corrupt);
        logic [15:0] c;
        logic [7:0]  body_b;
        logic [7:0]  flip;
        logic [7:0]  flip_hi;
        logic [7:0]  flip_lo;
        c = crc16_modbus(crcfc_pkg::CRC_INIT, hdr_cfg);
        send_plain(hdr_cfg);
        c = crc16_modbus(c, len[7:0]);
        send_plain(len[7:0]);
        for (int i = 2; i < len; i++)
        begin
            body_b = 8'($urandom_range(255));
            c = crc16_modbus(c, body_b);
            send_plain(body_b);
        end
        flip    = corrupt ? 8'($urandom_range(1, 255)) : 8'h00;
        flip_hi = 8'h00;
        flip_lo = 8'h00;
        if ($urandom_range(1))
            flip_hi = flip;
        else
            flip_lo = flip;
        send_plain(c[15:8] ^ flip_hi);
        send_plain(c[7:0] ^ flip_lo);
    endtask

    // mostly short lengths, now and then anything the limit allows
    function automatic int pick_length();
        int top;
        if (lim_cfg < 8'd3)
            return 2;
        top = int'(lim_cfg) - 1;
        if ($urandom_range(19) == 0)
            return $urandom_range(2, top);
        return $urandom_range(2, (top < 12) ? top : 12);
    endfunction

    // random traffic: mostly well-formed frames, the rest noise and broken frames
    task automatic run_random(input int unsigned n);
        int unsigned target;
        int unsigned pick;
        int          len;
        int          cut;
        logic [7:0]  bad_len;
        target = bytes_sent + n;
        while (bytes_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_frame(pick_length(), $urandom_range(99) < 15);
            else if (pick < 85)
            begin
                repeat ($urandom_range(1, 6))
                    send_plain(8'($urandom_range(255)));
            end
            else if (pick < 90)
            begin
                // header followed by an out-of-range length
                case ($urandom_range(2))
                    0: bad_len = 8'd0;
                    1: bad_len = 8'd1;
                    default: bad_len = 8'($urandom_range(lim_cfg, 255));
                endcase
                send_plain(hdr_cfg);
                send_plain(bad_len);
            end
            else if (pick < 95)
            begin
                // doubled header, then a frame
                send_plain(hdr_cfg);
                send_frame(pick_length(), 1'b0);
            end
            else
            begin
                // frame cut short; following bytes land in its body
                len = pick_length();
                cut = $urandom_range(0, len);
                send_plain(hdr_cfg);
                send_plain(len[7:0]);
                for (int i = 0; i < cut; i++)
                    send_plain(8'($urandom_range(255)));
            end
        end
    endtask

    function automatic void add_row(input byte_src_t src, input logic [7:0] value,
                                    input bit typed, input logic inf,
                                    input crcfc_pkg::status_t st, input logic [8:0] flen);
        script_row_t row;
        row.src         = src;
        row.value       = value;
        row.typed       = typed;
        row.want.echo   = value;
        row.want.inf    = inf;
        row.want.status = st;
        row.want.flen   = flen;
        script.push_back(row);
    endfunction

    // receiver: random stalls, quiet while calm, and a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_ask != hold_seen)
        begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(99) < 33);
    end

    // result checker: every beat that leaves is matched against the oldest expectation
    always @(posedge clk)
    begin
        frame_beat_t exp_beat;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("result beat with no byte outstanding: echo_byte %0h", echo_byte);
                mismatches++;
            end
            else
            begin
                exp_beat = expected_beats.pop_front();
                if (echo_byte !== exp_beat.echo)
                begin
                    $error("echo_byte: expected %0h, actual %0h", exp_beat.echo, echo_byte);
                    mismatches++;
                end
                if (in_frame !== exp_beat.inf)
                begin
                    $error("in_frame: expected %0d, actual %0d", exp_beat.inf, in_frame);
                    mismatches++;
                end
                if (frame_status !== exp_beat.status)
                begin
                    $error("frame_status: expected %0d, actual %0d",
                           exp_beat.status, frame_status);
                    mismatches++;
                end
                if (frame_length !== exp_beat.flen)
                begin
                    $error("frame_length: expected %0d, actual %0d",
                           exp_beat.flen, frame_length);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        script_row_t row;
        logic [7:0]  b;

        // directed table at reset settings (header 0x31, limit 0x31)
        add_row(SRC_LIT,     8'h00, 1'b1, 1'b0, crcfc_pkg::ST_HUNT,   9'd0);  // all zeros
        add_row(SRC_LIT,     8'hFF, 1'b1, 1'b0, crcfc_pkg::ST_HUNT,   9'd0);  // all ones
        add_row(SRC_LIT,     8'h31, 1'b1, 1'b1, crcfc_pkg::ST_INSIDE, 9'd0);  // header
        add_row(SRC_LIT,     8'h00, 1'b1, 1'b0, crcfc_pkg::ST_HUNT,   9'd0);  // length zero
        add_row(SRC_LIT,     8'h31, 1'b1, 1'b1, crcfc_pkg::ST_INSIDE, 9'd0);
        add_row(SRC_LIT,     8'h01, 1'b1, 1'b0, crcfc_pkg::ST_HUNT,   9'd0);  // length one
        add_row(SRC_LIT,     8'h31, 1'b1, 1'b1, crcfc_pkg::ST_INSIDE, 9'd0);
        add_row(SRC_LIT,     8'h31, 1'b1, 1'b1, crcfc_pkg::ST_INSIDE, 9'd0);  // len == header
        add_row(SRC_LIT,     8'h02, 1'b1, 1'b1, crcfc_pkg::ST_INSIDE, 9'd0);  // no body
        add_row(SRC_CRC_HI,  8'h00, 1'b0, 1'b1, crcfc_pkg::ST_INSIDE, 9'd0);
        add_row(SRC_CRC_LO,  8'h00, 1'b0, 1'b1, crcfc_pkg::ST_GOOD,   9'd4);
        add_row(SRC_LIT,     8'h31, 1'b1, 1'b1, crcfc_pkg::ST_INSIDE, 9'd0);  // one body byte
        add_row(SRC_LIT,     8'h03, 1'b1, 1'b1, crcfc_pkg::ST_INSIDE, 9'd0);
        add_row(SRC_LIT,     8'hAA, 1'b1, 1'b1, crcfc_pkg::ST_INSIDE, 9'd0);
        add_row(SRC_CRC_HI,  8'h00, 1'b0, 1'b1, crcfc_pkg::ST_INSIDE, 9'd0);
        add_row(SRC_CRC_BAD, 8'h00, 1'b0, 1'b1, crcfc_pkg::ST_BAD,    9'd0);  // crc mismatch
        add_row(SRC_LIT,     8'h31, 1'b1, 1'b1, crcfc_pkg::ST_INSIDE, 9'd0);
        add_row(SRC_LIT,     8'h32, 1'b1, 1'b0, crcfc_pkg::ST_HUNT,   9'd0);  // above limit
        add_row(SRC_LIT,     8'h31, 1'b1, 1'b1, crcfc_pkg::ST_INSIDE, 9'd0);
        add_row(SRC_LIT,     8'h04, 1'b1, 1'b1, crcfc_pkg::ST_INSIDE, 9'd0);
        add_row(SRC_LIT,     8'h00, 1'b1, 1'b1, crcfc_pkg::ST_INSIDE, 9'd0);
        add_row(SRC_LIT,     8'hFF, 1'b1, 1'b1, crcfc_pkg::ST_INSIDE, 9'd0);
        add_row(SRC_CRC_HI,  8'h00, 1'b0, 1'b1, crcfc_pkg::ST_INSIDE, 9'd0);
        add_row(SRC_CRC_LO,  8'h00, 1'b0, 1'b1, crcfc_pkg::ST_GOOD,   9'd6);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the table; crc rows take their byte from the tracker's running crc
        for (int i = 0; i < script.size(); i++)
        begin
            row = script[i];
            case (row.src)
                SRC_CRC_HI:  b = trk_crc[15:8];
                SRC_CRC_LO:  b = trk_crc[7:0];
                SRC_CRC_BAD: b = ~trk_crc[7:0];
                default:     b = row.value;
            endcase
            row.want.echo = b;
            send_byte(b, row.typed, row.want);
        end

        // reset settings; the receiver holds off while bytes keep coming, so the
        // input side must stall
        run_random(50);
        hold_ask <= hold_ask + 1;
        run_random(150);

        // header zero, widest limit, one frame of the longest length
        reconfigure(8'h00, 8'd255);
        run_random(200);
        send_frame(254, 1'b0);
        run_random(100);

        // header all ones, narrowest limit that still passes a frame (length two only)
        reconfigure(8'hFF, 8'd3);
        run_random(250);

        // limits that accept no frame at all
        reconfigure(8'h7E, 8'd2);
        run_random(150);
        reconfigure(8'hA5, 8'd0);
        run_random(100);

        // random settings, with a full pause mid-phase
        reconfigure(8'($urandom_range(255)), 8'($urandom_range(3, 255)));
        run_random(200);
        drain;
        run_random(200);

        // a stretch with no idling on either side
        reconfigure(8'h55, 8'h20);
        calm <= 1'b1;
        run_random(200);
        calm <= 1'b0;
        run_random(100);

        drain;
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
